[src/bots_pkg.sv]
// Package for the bulk-only transport host sequencer: transfer payload types,
// configuration bundle, action, status and event codes, and the phase encoding.
// No dependencies.
package bots_pkg;

    // Input event: one transfer on the input channel.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  cdb_bytes;
        logic [31:0] req_length;
        logic        direction_in;
        logic        has_buffer;
        logic        xfer_stalled;
        logic        xfer_failed;
        logic [31:0] xfer_bytes;
        logic [31:0] csw_signature;
        logic [31:0] csw_tag;
        logic [7:0]  csw_status;
        logic [31:0] csw_residue;
    } in_t;

    // Result: one transfer on the output channel.
    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  endpoint;
        logic [31:0] tag_out;
        logic [31:0] length_out;
        logic        direction_out;
        logic [3:0]  status;
        logic [31:0] residue;
        logic        last;
    } out_t;

    // Configuration registers as seen by the sequencer.
    typedef struct packed {
        logic [3:0] bulk_in_endpoint;
        logic [3:0] bulk_out_endpoint;
        logic [7:0] interface_number;
    } cfg_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_BULK_IN   = 2'd0;
    localparam logic [1:0] REG_BULK_OUT  = 2'd1;
    localparam logic [1:0] REG_INTERFACE = 2'd2;

    // Event kinds.
    localparam logic [1:0] MODE_CMD    = 2'd0;
    localparam logic [1:0] MODE_WRAP   = 2'd1;
    localparam logic [1:0] MODE_DATA   = 2'd2;
    localparam logic [1:0] MODE_STATUS = 2'd3;

    // Actions requested of the host controller.
    localparam logic [2:0] ACT_SEND  = 3'd0;
    localparam logic [2:0] ACT_DATA  = 3'd1;
    localparam logic [2:0] ACT_READ  = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_RESET = 3'd4;
    localparam logic [2:0] ACT_DONE  = 3'd5;
    localparam logic [2:0] ACT_IDLE  = 3'd6;

    // Completion status codes.
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_BAD_CDB   = 4'd1;
    localparam logic [3:0] ST_WRAP_FAIL = 4'd2;
    localparam logic [3:0] ST_DATA_FAIL = 4'd3;
    localparam logic [3:0] ST_SHORT     = 4'd4;
    localparam logic [3:0] ST_BAD_SIG   = 4'd5;
    localparam logic [3:0] ST_TAG_MISS  = 4'd6;
    localparam logic [3:0] ST_PHASE_ERR = 4'd7;
    localparam logic [3:0] ST_CMD_FAIL  = 4'd8;
    localparam logic [3:0] ST_SEQUENCE  = 4'd9;

    // Protocol constants.
    localparam logic [7:0]  MAX_CDB_BYTES = 8'd16;
    localparam logic [31:0] CBW_BYTES     = 32'd31;
    localparam logic [31:0] CSW_BYTES     = 32'd13;
    localparam logic [31:0] CSW_SIGNATURE = 32'h5342_5355;
    localparam logic [7:0]  CSW_GOOD      = 8'h00;
    localparam logic [7:0]  CSW_PHASE     = 8'h02;

    // Exchange phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_CBW  = 4'b0010,
        PH_DATA = 4'b0100,
        PH_CSW  = 4'b1000
    } phase_t;

endpackage

[src/bulk_only_transport_host_sequencer.sv]
// Top level of the bulk-only transport host sequencer: configuration registers,
// event register, sequencer core and result queue. Depends on bots_pkg,
// bots_core and bots_out_fifo.
//
//  Port group      Direction  Handshake              Payload
//  in_*            input      in_valid / in_ready    in_item  (in_t)
//  out_*           output     out_valid / out_ready  out_item (out_t)
//  cfg_*           input      cfg_write              cfg_index, cfg_data
//
// An event is registered on acceptance and decided once the result queue has room
// for two results, when its one or two results enter the queue together. One
// event per cycle is sustained while the queue has room for two results; the
// output side drains one result per cycle while out_ready is high.
// Reset leaves the sequencer idle with tag zero and endpoints in 1, out 2.
// A stalled output backs up into the event register and then into in_ready.
module bulk_only_transport_host_sequencer
    import bots_pkg::*;
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_item,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int FW = $clog2(OUT_DEPTH + 1);

    cfg_t          cfg_reg;
    in_t           item_reg;
    logic          item_valid_reg;
    logic          fire;
    logic          room;
    logic          pop;
    logic          two;
    out_t          res0;
    out_t          res1;
    logic [FW-1:0] fill;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bulk_in_endpoint  <= 4'd1;
            cfg_reg.bulk_out_endpoint <= 4'd2;
            cfg_reg.interface_number  <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BULK_IN:   cfg_reg.bulk_in_endpoint  <= cfg_data[3:0];
                REG_BULK_OUT:  cfg_reg.bulk_out_endpoint <= cfg_data[3:0];
                REG_INTERFACE: cfg_reg.interface_number  <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The registered event is decided once the queue can hold two results.
    assign room     = (fill <= FW'(OUT_DEPTH - 2));
    assign fire     = item_valid_reg && room;
    assign in_ready = !item_valid_reg || fire;
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    bots_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res0  (res0),
        .res1  (res1),
        .two   (two)
    );

    bots_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .two   (two),
        .d0    (res0),
        .d1    (res1),
        .pop   (pop),
        .q     (out_item),
        .valid (out_valid),
        .fill  (fill)
    );

    // The queue never overfills.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= FW'(OUT_DEPTH))
        else $error("result queue overfilled");

    // A pair of results is queued together.
    a_pair_push: assert property (@(posedge clk) disable iff (!rst_n)
        fire && two && !pop |=> fill == $past(fill) + FW'(2))
        else $error("result pair not queued together");

    // A result that is not the last of its event always has its partner queued.
    a_partner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.last |-> fill >= FW'(2))
        else $error("first result of a pair without its partner");

endmodule

[src/bots_core.sv]
// Sequencer core: exchange state and the single-pass decision logic that
// turns one registered event into one or two results. Depends on bots_pkg.
module bots_core
    import bots_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  in_t  item,
    input  cfg_t cfg,
    output out_t res0,
    output out_t res1,
    output logic two
);

    phase_t      phase_reg, phase_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] pend_len_reg, pend_len_next;
    logic        pend_dir_reg, pend_dir_next;
    logic        pend_data_reg, pend_data_next;
    logic [31:0] comp_res_reg, comp_res_next;
    logic        retried_reg, retried_next;

    logic        out_of_seq;
    logic [3:0]  data_ep;
    logic [32:0] short_diff;
    logic [31:0] short_residue;
    logic [31:0] reset_len;

    function automatic out_t mk(input logic [2:0] act, input logic [3:0] ep,
                                input logic [31:0] tag, input logic [31:0] len,
                                input logic dir, input logic [3:0] st,
                                input logic [31:0] res, input logic lst);
        out_t r;
        r.action        = act;
        r.endpoint      = ep;
        r.tag_out       = tag;
        r.length_out    = len;
        r.direction_out = dir;
        r.status        = st;
        r.residue       = res;
        r.last          = lst;
        return r;
    endfunction

    // Shared terms of the decision.
    assign data_ep       = pend_dir_reg ? cfg.bulk_in_endpoint : cfg.bulk_out_endpoint;
    assign short_diff    = {1'b0, pend_len_reg} - {1'b0, item.xfer_bytes};
    assign short_residue = short_diff[32] ? 32'd0 : short_diff[31:0];
    assign reset_len     = {24'd0, cfg.interface_number};

    // An event is out of sequence unless it matches the current phase.
    always_comb
    begin
        case (item.mode)
            MODE_CMD:    out_of_seq = (phase_reg != PH_IDLE);
            MODE_WRAP:   out_of_seq = (phase_reg != PH_CBW);
            MODE_DATA:   out_of_seq = (phase_reg != PH_DATA);
            MODE_STATUS: out_of_seq = (phase_reg != PH_CSW);
            default:     out_of_seq = 1'b1;
        endcase
    end

    // Decision logic: results and next state for the registered event.
    always_comb
    begin
        phase_next     = phase_reg;
        tag_next       = tag_reg;
        pend_len_next  = pend_len_reg;
        pend_dir_next  = pend_dir_reg;
        pend_data_next = pend_data_reg;
        comp_res_next  = comp_res_reg;
        retried_next   = retried_reg;
        two            = 1'b0;
        res0 = mk(ACT_IDLE, 4'd0, tag_reg, 32'd0, 1'b0, ST_SEQUENCE, 32'd0, 1'b1);
        res1 = mk(ACT_IDLE, 4'd0, tag_reg, 32'd0, 1'b0, ST_OK, 32'd0, 1'b1);
        if (!out_of_seq)
        begin
            case (item.mode)
                MODE_CMD:
                begin
                    if (item.cdb_bytes == 8'd0 || item.cdb_bytes > MAX_CDB_BYTES)
                    begin
                        res0 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_BAD_CDB,
                                  32'd0, 1'b1);
                    end
                    else
                    begin
                        tag_next       = tag_reg + 32'd1;
                        pend_len_next  = item.req_length;
                        pend_dir_next  = item.direction_in;
                        pend_data_next = (item.req_length != 32'd0) && item.has_buffer;
                        comp_res_next  = item.req_length;
                        retried_next   = 1'b0;
                        phase_next     = PH_CBW;
                        res0 = mk(ACT_SEND, cfg.bulk_out_endpoint, tag_reg + 32'd1,
                                  CBW_BYTES, 1'b0, ST_OK, 32'd0, 1'b1);
                    end
                end
                MODE_WRAP:
                begin
                    if (item.xfer_stalled)
                    begin
                        phase_next = PH_IDLE;
                        two        = 1'b1;
                        res0 = mk(ACT_RESET, 4'd0, tag_reg, reset_len, 1'b0, ST_OK,
                                  32'd0, 1'b0);
                        res1 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_WRAP_FAIL,
                                  32'd0, 1'b1);
                    end
                    else if (item.xfer_failed || item.xfer_bytes != CBW_BYTES)
                    begin
                        phase_next = PH_IDLE;
                        res0 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_WRAP_FAIL,
                                  32'd0, 1'b1);
                    end
                    else if (pend_data_reg)
                    begin
                        phase_next = PH_DATA;
                        res0 = mk(ACT_DATA, data_ep, tag_reg, pend_len_reg, pend_dir_reg,
                                  ST_OK, 32'd0, 1'b1);
                    end
                    else
                    begin
                        phase_next = PH_CSW;
                        res0 = mk(ACT_READ, cfg.bulk_in_endpoint, tag_reg, CSW_BYTES, 1'b1,
                                  ST_OK, 32'd0, 1'b1);
                    end
                end
                MODE_DATA:
                begin
                    if (item.xfer_stalled)
                    begin
                        comp_res_next = pend_len_reg;
                        phase_next    = PH_CSW;
                        two           = 1'b1;
                        res0 = mk(ACT_CLEAR, data_ep, tag_reg, 32'd0, pend_dir_reg, ST_OK,
                                  32'd0, 1'b0);
                        res1 = mk(ACT_READ, cfg.bulk_in_endpoint, tag_reg, CSW_BYTES, 1'b1,
                                  ST_OK, 32'd0, 1'b1);
                    end
                    else if (item.xfer_failed)
                    begin
                        phase_next = PH_IDLE;
                        res0 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_DATA_FAIL,
                                  32'd0, 1'b1);
                    end
                    else
                    begin
                        comp_res_next = short_residue;
                        phase_next    = PH_CSW;
                        res0 = mk(ACT_READ, cfg.bulk_in_endpoint, tag_reg, CSW_BYTES, 1'b1,
                                  ST_OK, 32'd0, 1'b1);
                    end
                end
                default:
                begin
                    // Status wrapper received: one retry on the first stall.
                    if (item.xfer_stalled && !retried_reg)
                    begin
                        retried_next = 1'b1;
                        two          = 1'b1;
                        res0 = mk(ACT_CLEAR, cfg.bulk_in_endpoint, tag_reg, 32'd0, 1'b1,
                                  ST_OK, 32'd0, 1'b0);
                        res1 = mk(ACT_READ, cfg.bulk_in_endpoint, tag_reg, CSW_BYTES, 1'b1,
                                  ST_OK, 32'd0, 1'b1);
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        res0 = mk(ACT_RESET, 4'd0, tag_reg, reset_len, 1'b0, ST_OK,
                                  32'd0, 1'b0);
                        two  = 1'b1;
                        if (item.xfer_stalled || item.xfer_failed ||
                            item.xfer_bytes != CSW_BYTES)
                        begin
                            res1 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_SHORT,
                                      32'd0, 1'b1);
                        end
                        else if (item.csw_signature != CSW_SIGNATURE)
                        begin
                            res1 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_BAD_SIG,
                                      32'd0, 1'b1);
                        end
                        else if (item.csw_tag != tag_reg)
                        begin
                            res1 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_TAG_MISS,
                                      32'd0, 1'b1);
                        end
                        else if (item.csw_status == CSW_PHASE)
                        begin
                            res1 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_PHASE_ERR,
                                      32'd0, 1'b1);
                        end
                        else if (item.csw_status != CSW_GOOD)
                        begin
                            two  = 1'b0;
                            res0 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_CMD_FAIL,
                                      32'd0, 1'b1);
                        end
                        else
                        begin
                            two  = 1'b0;
                            res0 = mk(ACT_DONE, 4'd0, tag_reg, 32'd0, 1'b0, ST_OK,
                                      (item.csw_residue != 32'd0) ? item.csw_residue
                                                                  : comp_res_reg,
                                      1'b1);
                        end
                    end
                end
            endcase
        end
    end

    // Exchange state, updated once per processed event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tag_reg       <= 32'd0;
            pend_len_reg  <= 32'd0;
            pend_dir_reg  <= 1'b0;
            pend_data_reg <= 1'b0;
            comp_res_reg  <= 32'd0;
            retried_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            tag_reg       <= tag_next;
            pend_len_reg  <= pend_len_next;
            pend_dir_reg  <= pend_dir_next;
            pend_data_reg <= pend_data_next;
            comp_res_reg  <= comp_res_next;
            retried_reg   <= retried_next;
        end
    end

endmodule

[src/bots_out_fifo.sv]
// Result queue: takes one or two results per cycle and hands them out one
// transfer at a time. Depends on bots_pkg.
module bots_out_fifo
    import bots_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       two,
    input  out_t                       d0,
    input  out_t                       d1,
    input  logic                       pop,
    output out_t                       q,
    output logic                       valid,
    output logic [$clog2(DEPTH+1)-1:0] fill
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    out_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] wr_ptr_inc;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] push_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + PW'(1);
    endfunction

    assign wr_ptr_inc = bump(wr_ptr_reg);
    assign push_cnt   = push ? (two ? FW'(2) : FW'(1)) : FW'(0);

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (push)
        begin
            wr_ptr_next = two ? bump(wr_ptr_inc) : wr_ptr_inc;
        end
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg + push_cnt - (pop ? FW'(1) : FW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Result storage; the second result of a pair goes in the following slot.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= d0;
            if (two)
            begin
                mem[wr_ptr_inc] <= d1;
            end
        end
    end

    assign q     = mem[rd_ptr_reg];
    assign valid = (fill_reg != '0);
    assign fill  = fill_reg;

endmodule

[test/tb_bulk_only_transport_host_sequencer.sv]
// Self-checking testbench for the bulk-only transport host sequencer.
// Depends on bots_pkg and the sequencer RTL; the expected actions come from a
// behavioural predictor in this file, and the stimulus from a queued driver.
module tb_bulk_only_transport_host_sequencer;
    import bots_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    // Predictor state of one exchange.
    typedef struct packed {
        phase_t      phase;
        logic [31:0] tag;
        logic [31:0] pend_len;
        logic        pend_dir;
        logic        pend_data;
        logic [31:0] left_over;
        logic        retried;
    } seq_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_item;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = REG_BULK_IN;
    logic [7:0] cfg_data = 8'd0;

    in_t        host_events[$];
    out_t       awaited_actions[$];
    seq_state_t live_state;
    seq_state_t plan_state;
    cfg_t       live_cfg;
    cfg_t       plan_cfg;
    int         events_queued = 0;
    int         events_taken = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_left = 0;
    logic       in_fire = 1'b0;

    bulk_only_transport_host_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Counts failures and prints one line for each of them.
    task automatic note_failure(input string msg);
        fail_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            note_failure($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic seq_state_t idle_state();
        seq_state_t s;
        s = '0;
        s.phase = PH_IDLE;
        return s;
    endfunction

    function automatic out_t make_action(input logic [2:0] act, input logic [3:0] ep,
                                         input logic [31:0] tag, input logic [31:0] len,
                                         input logic dir, input logic [3:0] st,
                                         input logic [31:0] res, input logic last);
        out_t r;
        r.action = act;
        r.endpoint = ep;
        r.tag_out = tag;
        r.length_out = len;
        r.direction_out = dir;
        r.status = st;
        r.residue = res;
        r.last = last;
        return r;
    endfunction

    // Works out the one or two actions that an event causes and moves the
    // exchange on.
    task automatic predict_actions(inout seq_state_t s, input cfg_t c, input in_t ev,
                                   output out_t r0, output out_t r1, output int n);
        phase_t      want_phase;
        logic [3:0]  data_ep;
        logic        ended;
        logic        recover;
        logic [3:0]  verdict;
        ended = 1'b0;
        recover = 1'b0;
        verdict = ST_OK;
        n = 1;
        r1 = '0;
        case (ev.mode)
            MODE_CMD:  want_phase = PH_IDLE;
            MODE_WRAP: want_phase = PH_CBW;
            MODE_DATA: want_phase = PH_DATA;
            default:   want_phase = PH_CSW;
        endcase
        data_ep = s.pend_dir ? c.bulk_in_endpoint : c.bulk_out_endpoint;

        if (s.phase != want_phase) begin
            // Event out of sequence: state is left alone.
            r0 = make_action(ACT_IDLE, 4'd0, s.tag, 32'd0, 1'b0, ST_SEQUENCE, 32'd0, 1'b1);
        end else begin
            case (ev.mode)
                MODE_CMD: begin
                    if (ev.cdb_bytes < 8'd1 || ev.cdb_bytes > MAX_CDB_BYTES) begin
                        ended = 1'b1;
                        verdict = ST_BAD_CDB;
                    end else begin
                        s.tag = s.tag + 32'd1;
                        s.pend_len = ev.req_length;
                        s.pend_dir = ev.direction_in;
                        s.pend_data = (ev.req_length != 32'd0) && ev.has_buffer;
                        s.left_over = ev.req_length;
                        s.retried = 1'b0;
                        s.phase = PH_CBW;
                        r0 = make_action(ACT_SEND, c.bulk_out_endpoint, s.tag, CBW_BYTES,
                                         1'b0, ST_OK, 32'd0, 1'b1);
                    end
                end
                MODE_WRAP: begin
                    if (ev.xfer_stalled) begin
                        ended = 1'b1;
                        recover = 1'b1;
                        verdict = ST_WRAP_FAIL;
                    end else if (ev.xfer_failed || ev.xfer_bytes != CBW_BYTES) begin
                        ended = 1'b1;
                        verdict = ST_WRAP_FAIL;
                    end else if (s.pend_data) begin
                        s.phase = PH_DATA;
                        r0 = make_action(ACT_DATA, data_ep, s.tag, s.pend_len, s.pend_dir,
                                         ST_OK, 32'd0, 1'b1);
                    end else begin
                        s.phase = PH_CSW;
                        r0 = make_action(ACT_READ, c.bulk_in_endpoint, s.tag, CSW_BYTES,
                                         1'b1, ST_OK, 32'd0, 1'b1);
                    end
                end
                MODE_DATA: begin
                    if (ev.xfer_stalled) begin
                        // Stalled data phase: clear the halt, then read status.
                        s.left_over = s.pend_len;
                        s.phase = PH_CSW;
                        r0 = make_action(ACT_CLEAR, data_ep, s.tag, 32'd0, s.pend_dir,
                                         ST_OK, 32'd0, 1'b0);
                        r1 = make_action(ACT_READ, c.bulk_in_endpoint, s.tag, CSW_BYTES,
                                         1'b1, ST_OK, 32'd0, 1'b1);
                        n = 2;
                    end else if (ev.xfer_failed) begin
                        ended = 1'b1;
                        verdict = ST_DATA_FAIL;
                    end else begin
                        s.left_over = (ev.xfer_bytes >= s.pend_len) ? 32'd0
                                      : s.pend_len - ev.xfer_bytes;
                        s.phase = PH_CSW;
                        r0 = make_action(ACT_READ, c.bulk_in_endpoint, s.tag, CSW_BYTES,
                                         1'b1, ST_OK, 32'd0, 1'b1);
                    end
                end
                default: begin
                    if (ev.xfer_stalled && !s.retried) begin
                        // First status stall is retried once after a halt clear.
                        s.retried = 1'b1;
                        r0 = make_action(ACT_CLEAR, c.bulk_in_endpoint, s.tag, 32'd0, 1'b1,
                                         ST_OK, 32'd0, 1'b0);
                        r1 = make_action(ACT_READ, c.bulk_in_endpoint, s.tag, CSW_BYTES,
                                         1'b1, ST_OK, 32'd0, 1'b1);
                        n = 2;
                    end else begin
                        ended = 1'b1;
                        recover = 1'b1;
                        if (ev.xfer_stalled || ev.xfer_failed || ev.xfer_bytes != CSW_BYTES)
                            verdict = ST_SHORT;
                        else if (ev.csw_signature != CSW_SIGNATURE)
                            verdict = ST_BAD_SIG;
                        else if (ev.csw_tag != s.tag)
                            verdict = ST_TAG_MISS;
                        else if (ev.csw_status == CSW_PHASE)
                            verdict = ST_PHASE_ERR;
                        else begin
                            recover = 1'b0;
                            verdict = (ev.csw_status != CSW_GOOD) ? ST_CMD_FAIL : ST_OK;
                        end
                    end
                end
            endcase

            // Completion of the exchange, with reset recovery where called for.
            if (ended) begin
                s.phase = PH_IDLE;
                if (recover) begin
                    r0 = make_action(ACT_RESET, 4'd0, s.tag, {24'd0, c.interface_number},
                                     1'b0, ST_OK, 32'd0, 1'b0);
                    r1 = make_action(ACT_DONE, 4'd0, s.tag, 32'd0, 1'b0, verdict, 32'd0, 1'b1);
                    n = 2;
                end else begin
                    r0 = make_action(ACT_DONE, 4'd0, s.tag, 32'd0, 1'b0, verdict,
                                     (verdict == ST_OK) ? ((ev.csw_residue != 32'd0)
                                     ? ev.csw_residue : s.left_over) : 32'd0, 1'b1);
                end
            end
        end
    endtask

    // Event builders; every field not named is random.
    function automatic in_t any_event(input logic [1:0] mode);
        in_t ev;
        ev.mode = mode;
        ev.cdb_bytes = 8'($urandom);
        ev.req_length = $urandom;
        ev.direction_in = 1'($urandom);
        ev.has_buffer = 1'($urandom);
        ev.xfer_stalled = 1'($urandom);
        ev.xfer_failed = 1'($urandom);
        ev.xfer_bytes = $urandom;
        ev.csw_signature = $urandom;
        ev.csw_tag = $urandom;
        ev.csw_status = 8'($urandom);
        ev.csw_residue = $urandom;
        return ev;
    endfunction

    function automatic in_t cmd_event(input logic [7:0] cdb, input logic [31:0] len,
                                      input logic dir, input logic buffered);
        in_t ev;
        ev = any_event(MODE_CMD);
        ev.cdb_bytes = cdb;
        ev.req_length = len;
        ev.direction_in = dir;
        ev.has_buffer = buffered;
        return ev;
    endfunction

    function automatic in_t xfer_event(input logic [1:0] mode, input logic stalled,
                                       input logic failed, input logic [31:0] bytes);
        in_t ev;
        ev = any_event(mode);
        ev.xfer_stalled = stalled;
        ev.xfer_failed = failed;
        ev.xfer_bytes = bytes;
        return ev;
    endfunction

    function automatic in_t status_event(input logic stalled, input logic failed,
                                         input logic [31:0] bytes, input logic [31:0] sig,
                                         input logic [31:0] tag, input logic [7:0] st,
                                         input logic [31:0] res);
        in_t ev;
        ev = xfer_event(MODE_STATUS, stalled, failed, bytes);
        ev.csw_signature = sig;
        ev.csw_tag = tag;
        ev.csw_status = st;
        ev.csw_residue = res;
        return ev;
    endfunction

    // Queues an event and follows it with the planning copy of the state.
    task automatic queue_event(input in_t ev);
        out_t r0;
        out_t r1;
        int   n;
        predict_actions(plan_state, plan_cfg, ev, r0, r1, n);
        host_events.push_back(ev);
        events_queued++;
    endtask

    // Mostly well-formed exchanges with random outcomes, some noise.
    task automatic queue_random_event();
        in_t         ev;
        logic [31:0] len;
        logic [31:0] bytes;
        if ($urandom_range(99) < 8) begin
            ev = any_event(2'($urandom));
        end else begin
            case (plan_state.phase)
                PH_IDLE: begin
                    case ($urandom_range(9))
                        0:       len = 32'd0;
                        1:       len = 32'hFFFF_FFFF;
                        2, 3, 4: len = $urandom_range(1, 4096);
                        default: len = $urandom;
                    endcase
                    ev = cmd_event(($urandom_range(99) < 90) ? 8'($urandom_range(1, 16))
                                   : 8'($urandom), len, 1'($urandom),
                                   $urandom_range(99) < 85);
                end
                PH_CBW: begin
                    ev = xfer_event(MODE_WRAP, $urandom_range(99) < 7, $urandom_range(99) < 7,
                                    ($urandom_range(99) < 90) ? CBW_BYTES : $urandom);
                end
                PH_DATA: begin
                    case ($urandom_range(3))
                        0:       bytes = plan_state.pend_len;
                        1:       bytes = plan_state.pend_len - $urandom_range(0, 64);
                        2:       bytes = plan_state.pend_len + $urandom_range(0, 64);
                        default: bytes = $urandom;
                    endcase
                    ev = xfer_event(MODE_DATA, $urandom_range(99) < 10,
                                    $urandom_range(99) < 8, bytes);
                end
                default: begin
                    ev = status_event($urandom_range(99) < 12, $urandom_range(99) < 5,
                                      ($urandom_range(99) < 92) ? CSW_BYTES : $urandom,
                                      ($urandom_range(99) < 92) ? CSW_SIGNATURE : $urandom,
                                      ($urandom_range(99) < 92) ? plan_state.tag : $urandom,
                                      ($urandom_range(99) < 80) ? CSW_GOOD
                                      : (($urandom_range(99) < 40) ? CSW_PHASE
                                      : 8'($urandom)),
                                      ($urandom_range(1) == 0) ? 32'd0 : $urandom);
                end
            endcase
        end
        queue_event(ev);
    endtask

    // Waits until every queued event has been taken and every action seen.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (events_taken != events_queued || awaited_actions.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_BULK_IN:  plan_cfg.bulk_in_endpoint = value[3:0];
            REG_BULK_OUT: plan_cfg.bulk_out_endpoint = value[3:0];
            default:      plan_cfg.interface_number = value;
        endcase
    endtask

    task automatic set_config(input logic [3:0] ep_in, input logic [3:0] ep_out,
                              input logic [7:0] intf);
        write_reg(REG_BULK_IN, {4'($urandom), ep_in});
        write_reg(REG_BULK_OUT, {4'($urandom), ep_out});
        write_reg(REG_INTERFACE, intf);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Driver: presents the next queued event once the previous transfer is done.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_fire)) begin
            if (host_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item <= host_events.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is running.
    always @(negedge clk) begin
        out_ready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: follows configuration writes, predicts on every accepted event
    // and checks every accepted action against the oldest expectation.
    always @(posedge clk) begin : monitor
        out_t r0;
        out_t r1;
        out_t want;
        int   n;
        if (rst_n) begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_BULK_IN:   live_cfg.bulk_in_endpoint = cfg_data[3:0];
                    REG_BULK_OUT:  live_cfg.bulk_out_endpoint = cfg_data[3:0];
                    REG_INTERFACE: live_cfg.interface_number = cfg_data;
                    default:       ;
                endcase
            end
            if (in_valid && in_ready) begin
                predict_actions(live_state, live_cfg, in_item, r0, r1, n);
                awaited_actions.push_back(r0);
                if (n == 2)
                    awaited_actions.push_back(r1);
                events_taken++;
            end
            if (out_valid && out_ready) begin
                if (awaited_actions.size() == 0) begin
                    note_failure($sformatf("unexpected action %0d, status %0d",
                                           out_item.action, out_item.status));
                end else begin
                    want = awaited_actions.pop_front();
                    compare_field("action", 32'(out_item.action), 32'(want.action));
                    compare_field("endpoint", 32'(out_item.endpoint), 32'(want.endpoint));
                    compare_field("tag_out", out_item.tag_out, want.tag_out);
                    compare_field("length_out", out_item.length_out, want.length_out);
                    compare_field("direction_out", 32'(out_item.direction_out),
                                  32'(want.direction_out));
                    compare_field("status", 32'(out_item.status), 32'(want.status));
                    compare_field("residue", out_item.residue, want.residue);
                    compare_field("last", 32'(out_item.last), 32'(want.last));
                end
            end
            in_fire <= in_valid && in_ready;
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        live_state = idle_state();
        plan_state = idle_state();
        live_cfg = '{bulk_in_endpoint: 4'd1, bulk_out_endpoint: 4'd2, interface_number: 8'd0};
        plan_cfg = live_cfg;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: sequence errors, descriptor length limits, stalls on every
        // phase, the status retry, no-data commands and the residue rules.
        queue_event(status_event(1'b0, 1'b0, CSW_BYTES, CSW_SIGNATURE, 32'd0, CSW_GOOD, 32'd0));
        queue_event(cmd_event(8'd0, 32'd64, 1'b1, 1'b1));
        queue_event(cmd_event(8'd17, 32'd64, 1'b1, 1'b1));
        queue_event(cmd_event(8'd255, 32'd64, 1'b0, 1'b1));
        queue_event(cmd_event(8'd16, 32'hFFFF_FFFF, 1'b1, 1'b1));
        queue_event(cmd_event(8'd1, 32'd8, 1'b0, 1'b1));
        queue_event(xfer_event(MODE_DATA, 1'b0, 1'b0, 32'd0));
        queue_event(xfer_event(MODE_WRAP, 1'b0, 1'b0, CBW_BYTES));
        queue_event(xfer_event(MODE_DATA, 1'b0, 1'b0, 32'd0));
        queue_event(status_event(1'b1, 1'b0, 32'd0, 32'd0, 32'd0, CSW_GOOD, 32'd0));
        queue_event(status_event(1'b1, 1'b0, 32'd0, 32'd0, 32'd0, CSW_GOOD, 32'd0));
        queue_event(cmd_event(8'd1, 32'd0, 1'b1, 1'b1));
        queue_event(xfer_event(MODE_WRAP, 1'b1, 1'b1, CBW_BYTES));
        queue_event(cmd_event(8'd6, 32'd100, 1'b0, 1'b0));
        queue_event(xfer_event(MODE_WRAP, 1'b0, 1'b0, CBW_BYTES));
        queue_event(status_event(1'b0, 1'b0, CSW_BYTES, CSW_SIGNATURE, plan_state.tag,
                                 CSW_GOOD, 32'd0));
        queue_event(cmd_event(8'd12, 32'd512, 1'b0, 1'b1));
        queue_event(xfer_event(MODE_WRAP, 1'b0, 1'b0, CBW_BYTES));
        queue_event(xfer_event(MODE_DATA, 1'b0, 1'b1, 32'd512));
        queue_event(cmd_event(8'd10, 32'd512, 1'b1, 1'b1));
        queue_event(xfer_event(MODE_WRAP, 1'b0, 1'b0, CBW_BYTES));
        queue_event(xfer_event(MODE_DATA, 1'b1, 1'b0, 32'd0));
        queue_event(status_event(1'b0, 1'b0, CSW_BYTES, CSW_SIGNATURE, plan_state.tag,
                                 CSW_PHASE, 32'd0));
        queue_event(cmd_event(8'd10, 32'd0, 1'b0, 1'b0));
        queue_event(xfer_event(MODE_WRAP, 1'b0, 1'b0, 32'd30));
        wait_drained();

        // Extreme endpoints and interface, no idling on either side.
        set_config(4'd15, 4'd1, 8'd255);
        repeat (190) queue_random_event();
        wait_drained();

        // Opposite extremes, sender idling.
        set_config(4'd1, 4'd15, 8'd0);
        send_idle_pct = 45;
        repeat (190) queue_random_event();
        wait_drained();

        // Random settings, receiver stalling, opening with a long hold-off
        // while the sender keeps offering so that the block backs up.
        set_config(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)), 8'($urandom));
        send_idle_pct = 0;
        recv_stall_pct = 45;
        hold_left = 400;
        repeat (190) queue_random_event();
        wait_drained();

        // Random settings, both sides idling.
        set_config(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)), 8'($urandom));
        send_idle_pct = 28;
        recv_stall_pct = 28;
        repeat (255) queue_random_event();
        wait_drained();
        repeat (10) @(negedge clk);

        while (awaited_actions.size() != 0)
            note_failure($sformatf("action %0d never arrived",
                                   awaited_actions.pop_front().action));
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
